/* hw/rtl/bcn_pkg.sv */
// Shared types and constants for the beacon table.
package bcn_pkg;

    localparam logic [1:0] CMD_SIGHT  = 2'd0;
    localparam logic [1:0] CMD_SWEEP  = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] CFG_SHOW_ALL = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_ALPHA    = 2'd2;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_SWEPT = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    localparam logic [8:0] ALPHA_ONE = 9'd256;

    typedef enum logic [1:0] {
        OP_SIGHT,
        OP_IGNORE,
        OP_SWEEP,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [31:0]       now;
        logic [31:0]       id;
        logic [7:0]        bat;
        logic [7:0]        typ;
        logic signed [7:0] rssi;
    } req_t;

    typedef struct packed {
        logic [31:0]        id;
        logic signed [15:0] rssi;
        logic [7:0]         bat;
        logic [7:0]         typ;
        logic [31:0]        seen;
    } entry_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [31:0] id;
        logic [7:0]  rssi;
        logic [7:0]  bat;
        logic [7:0]  typ;
        logic [31:0] seen;
    } swept_t;

    function automatic logic [7:0] rssi_int(input logic signed [15:0] v);
        logic signed [16:0] t;
        t = 17'(v) + (v[15] ? 17'sd255 : 17'sd0);
        return t[15:8];
    endfunction

endpackage

/* hw/rtl/beacon_table_with_ema_and_aging_top.sv */
// Top level of the beacon table with smoothed strength and aging.
// A request is taken when start is high and busy is low (the unused command is dropped);
// two requests can be queued while the sequencer works. Each result appears for one cycle
// with result_valid and cannot be stalled. A sighting compares the stored entries one at a
// time, then smooths a hit or inserts or drops the beacon; a report walks the entries, and
// a sweep checks each entry, moving the last one into each removed slot, then delivers the
// removed entries; the single read port of the entry RAM makes these walks sequential.
module beacon_table_with_ema_and_aging_top #(
    parameter int MAX_BEACONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        cmd,
    input  logic [31:0]       now_ms,
    input  logic              has_data,
    input  logic [31:0]       beacon_id,
    input  logic [31:0]       mac_id,
    input  logic [7:0]        battery_in,
    input  logic [7:0]        type_in,
    input  logic signed [7:0] rssi,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              result_valid,
    output logic [2:0]        status,
    output logic [3:0]        slot,
    output logic [31:0]       entry_id,
    output logic signed [7:0] rssi_out,
    output logic [7:0]        battery_out,
    output logic [7:0]        type_out,
    output logic [31:0]       last_seen_out,
    output logic [4:0]        occupancy,
    output logic              last
);
    logic          show_all_reg;
    logic [31:0]   timeout_reg;
    logic [8:0]    alpha_reg;
    bcn_pkg::req_t req;
    logic          req_valid, req_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_all_reg <= 1'b0;
            timeout_reg <= 32'd120000;
            alpha_reg <= 9'd77;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bcn_pkg::CFG_SHOW_ALL: show_all_reg <= cfg_data[0];
                bcn_pkg::CFG_TIMEOUT:  timeout_reg <= cfg_data;
                bcn_pkg::CFG_ALPHA:    alpha_reg <= cfg_data[8:0];
                default:               alpha_reg <= alpha_reg;
            endcase
        end
    end

    bcn_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .now_ms(now_ms),
        .has_data(has_data), .beacon_id(beacon_id), .mac_id(mac_id),
        .battery_in(battery_in), .type_in(type_in), .rssi(rssi),
        .show_all(show_all_reg), .req(req), .req_valid(req_valid), .req_pop(req_pop)
    );

    bcn_back #(.MAX_BEACONS(MAX_BEACONS)) u_back (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid), .req_pop(req_pop),
        .timeout_ms(timeout_reg), .alpha_q8(alpha_reg), .result_valid(result_valid),
        .status(status), .slot(slot), .entry_id(entry_id), .rssi_out(rssi_out),
        .battery_out(battery_out), .type_out(type_out), .last_seen_out(last_seen_out),
        .occupancy(occupancy), .last(last)
    );
endmodule

/* hw/rtl/bcn_ram.sv */
// Generic single write port RAM with a registered read port.
module bcn_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                   wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                   rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/bcn_front.sv */
// Request intake: classifies commands and queues them for the sequencer.
module bcn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        cmd,
    input  logic [31:0]       now_ms,
    input  logic              has_data,
    input  logic [31:0]       beacon_id,
    input  logic [31:0]       mac_id,
    input  logic [7:0]        battery_in,
    input  logic [7:0]        type_in,
    input  logic signed [7:0] rssi,
    input  logic              show_all,
    output bcn_pkg::req_t     req,
    output logic              req_valid,
    input  logic              req_pop
);
    bcn_pkg::req_t q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    bcn_pkg::req_t cls;
    logic       push;

    always_comb
    begin
        cls.now = now_ms;
        cls.rssi = rssi;
        cls.id = has_data ? beacon_id : mac_id;
        cls.bat = has_data ? battery_in : 8'd0;
        cls.typ = has_data ? type_in : 8'd0;
        case (cmd)
            bcn_pkg::CMD_SIGHT:
                cls.op = (has_data || show_all) ? bcn_pkg::OP_SIGHT : bcn_pkg::OP_IGNORE;
            bcn_pkg::CMD_SWEEP:  cls.op = bcn_pkg::OP_SWEEP;
            bcn_pkg::CMD_REPORT: cls.op = bcn_pkg::OP_REPORT;
            default:             cls.op = bcn_pkg::OP_IGNORE;
        endcase
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy && (cmd != bcn_pkg::CMD_UNUSED);
    assign req = q_reg[rp_reg];
    assign req_valid = (cnt_reg != 2'd0);
    assign wp_next = push ? ~wp_reg : wp_reg;
    assign rp_next = req_pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, req_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end
endmodule

/* hw/rtl/bcn_back.sv */
// Table sequencer: lookup, insert, smoothing, sweep and report walks.
module bcn_back #(
    parameter int MAX_BEACONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bcn_pkg::req_t     req,
    input  logic              req_valid,
    output logic              req_pop,
    input  logic [31:0]       timeout_ms,
    input  logic [8:0]        alpha_q8,
    output logic              result_valid,
    output logic [2:0]        status,
    output logic [3:0]        slot,
    output logic [31:0]       entry_id,
    output logic signed [7:0] rssi_out,
    output logic [7:0]        battery_out,
    output logic [7:0]        type_out,
    output logic [31:0]       last_seen_out,
    output logic [4:0]        occupancy,
    output logic              last
);
    localparam int IW = (MAX_BEACONS > 1) ? $clog2(MAX_BEACONS) : 1;
    localparam int CW = $clog2(MAX_BEACONS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BEACONS);

    typedef enum logic [3:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_EMA, S_UPD, S_SW_RD, S_SW_CHK, S_SW_MV,
        S_EM_RD, S_EM_OUT, S_RP_RD, S_RP_OUT
    } state_t;

    state_t          state_reg;
    bcn_pkg::req_t   cur_reg;
    logic [CW-1:0]   count_reg, idx_reg, k_reg, j_reg;
    logic signed [17:0] pa_reg;
    logic signed [25:0] pb_reg;
    logic signed [15:0] ema_reg;
    logic [8:0]      a_sat;
    logic signed [31:0] n_sum, r_sh;
    logic signed [15:0] r_sat;

    logic            tw_en;
    logic [IW-1:0]   tw_addr, tr_addr;
    bcn_pkg::entry_t tw_data, tr_data;
    logic            bw_en;
    bcn_pkg::swept_t bw_data, br_data;
    logic [31:0]     age;

    logic            ov_reg;
    logic [2:0]      status_reg;
    logic [3:0]      slot_reg;
    logic [31:0]     id_reg, seen_reg;
    logic [7:0]      rssi_o_reg, bat_reg, typ_reg;
    logic [4:0]      occ_reg;
    logic            last_reg;

    assign a_sat = (alpha_q8 > bcn_pkg::ALPHA_ONE) ? bcn_pkg::ALPHA_ONE : alpha_q8;
    assign n_sum = (32'(pa_reg) <<< 8) + 32'(pb_reg);
    assign r_sh = n_sum >>> 8;
    assign r_sat = (r_sh > 32'sd32767) ? 16'sh7fff :
                   (r_sh < -32'sd32768) ? 16'sh8000 : r_sh[15:0];
    assign age = cur_reg.now - tr_data.seen;
    assign req_pop = (state_reg == S_IDLE) && req_valid;

    always_comb
    begin
        tr_addr = idx_reg[IW-1:0];
        tw_en = 1'b0;
        tw_addr = idx_reg[IW-1:0];
        tw_data = tr_data;
        bw_en = 1'b0;
        bw_data.slot = 4'(idx_reg);
        bw_data.id = tr_data.id;
        bw_data.rssi = bcn_pkg::rssi_int(tr_data.rssi);
        bw_data.bat = tr_data.bat;
        bw_data.typ = tr_data.typ;
        bw_data.seen = tr_data.seen;
        case (state_reg)
            S_LK_RD:
            begin
                tw_data = '{cur_reg.id, {cur_reg.rssi, 8'd0}, cur_reg.bat, cur_reg.typ,
                            cur_reg.now};
                tw_en = (idx_reg == count_reg) && (count_reg < MAXC);
            end
            S_UPD:
            begin
                tw_data = '{cur_reg.id, ema_reg, cur_reg.bat, cur_reg.typ, cur_reg.now};
                tw_en = 1'b1;
            end
            S_SW_CHK:
            begin
                tr_addr = IW'(count_reg - CW'(1));
                bw_en = (age > timeout_ms);
            end
            S_SW_MV:
            begin
                tw_en = 1'b1;
            end
            default:
            begin
                tw_en = 1'b0;
            end
        endcase
    end

    bcn_ram #(.W($bits(bcn_pkg::entry_t)), .D(MAX_BEACONS)) u_table (
        .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
        .raddr(tr_addr), .rdata(tr_data)
    );

    bcn_ram #(.W($bits(bcn_pkg::swept_t)), .D(MAX_BEACONS)) u_swept (
        .clk(clk), .we(bw_en), .waddr(k_reg[IW-1:0]), .wdata(bw_data),
        .raddr(j_reg[IW-1:0]), .rdata(br_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cur_reg <= req;
                        idx_reg <= '0;
                        k_reg <= '0;
                        j_reg <= '0;
                        case (req.op)
                            bcn_pkg::OP_SIGHT: state_reg <= S_LK_RD;
                            bcn_pkg::OP_SWEEP: state_reg <= S_SW_RD;
                            bcn_pkg::OP_REPORT:
                            begin
                                if (count_reg == '0)
                                begin
                                    ov_reg <= 1'b1;
                                    status_reg <= bcn_pkg::ST_EMPTY;
                                    slot_reg <= '0; id_reg <= '0; rssi_o_reg <= '0;
                                    bat_reg <= '0; typ_reg <= '0; seen_reg <= '0;
                                    occ_reg <= 5'(count_reg); last_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_RP_RD;
                                end
                            end
                            default:
                            begin
                                ov_reg <= 1'b1;
                                status_reg <= bcn_pkg::ST_IGNORED;
                                slot_reg <= '0; id_reg <= '0; rssi_o_reg <= '0;
                                bat_reg <= '0; typ_reg <= '0; seen_reg <= '0;
                                occ_reg <= 5'(count_reg); last_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LK_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        ov_reg <= 1'b1;
                        last_reg <= 1'b1;
                        id_reg <= cur_reg.id;
                        state_reg <= S_IDLE;
                        if (count_reg < MAXC)
                        begin
                            status_reg <= bcn_pkg::ST_INSERTED;
                            slot_reg <= 4'(count_reg);
                            rssi_o_reg <= cur_reg.rssi;
                            bat_reg <= cur_reg.bat;
                            typ_reg <= cur_reg.typ;
                            seen_reg <= cur_reg.now;
                            count_reg <= count_reg + CW'(1);
                            occ_reg <= 5'(count_reg + CW'(1));
                        end
                        else
                        begin
                            status_reg <= bcn_pkg::ST_FULL;
                            slot_reg <= '0; rssi_o_reg <= '0;
                            bat_reg <= '0; typ_reg <= '0; seen_reg <= '0;
                            occ_reg <= 5'(count_reg);
                        end
                    end
                    else
                    begin
                        state_reg <= S_LK_CMP;
                    end
                end
                S_LK_CMP:
                begin
                    if (tr_data.id == cur_reg.id)
                    begin
                        pa_reg <= $signed({1'b0, a_sat}) * cur_reg.rssi;
                        pb_reg <= $signed({1'b0, 9'(bcn_pkg::ALPHA_ONE - a_sat)}) * tr_data.rssi;
                        state_reg <= S_EMA;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_LK_RD;
                    end
                end
                S_EMA:
                begin
                    ema_reg <= r_sat;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    ov_reg <= 1'b1;
                    status_reg <= bcn_pkg::ST_UPDATED;
                    slot_reg <= 4'(idx_reg);
                    id_reg <= cur_reg.id;
                    rssi_o_reg <= bcn_pkg::rssi_int(ema_reg);
                    bat_reg <= cur_reg.bat;
                    typ_reg <= cur_reg.typ;
                    seen_reg <= cur_reg.now;
                    occ_reg <= 5'(count_reg);
                    last_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SW_RD:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        state_reg <= (k_reg == '0) ? S_IDLE : S_EM_RD;
                    end
                    else
                    begin
                        state_reg <= S_SW_CHK;
                    end
                end
                S_SW_CHK:
                begin
                    if (age > timeout_ms)
                    begin
                        k_reg <= k_reg + CW'(1);
                        state_reg <= S_SW_MV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_SW_RD;
                    end
                end
                S_SW_MV:
                begin
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_SW_RD;
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    ov_reg <= 1'b1;
                    status_reg <= bcn_pkg::ST_SWEPT;
                    slot_reg <= br_data.slot;
                    id_reg <= br_data.id;
                    rssi_o_reg <= br_data.rssi;
                    bat_reg <= br_data.bat;
                    typ_reg <= br_data.typ;
                    seen_reg <= br_data.seen;
                    occ_reg <= 5'(count_reg);
                    last_reg <= (j_reg == k_reg - CW'(1));
                    j_reg <= j_reg + CW'(1);
                    state_reg <= (j_reg == k_reg - CW'(1)) ? S_IDLE : S_EM_RD;
                end
                S_RP_RD:
                begin
                    state_reg <= S_RP_OUT;
                end
                S_RP_OUT:
                begin
                    ov_reg <= 1'b1;
                    status_reg <= bcn_pkg::ST_REPORT;
                    slot_reg <= 4'(idx_reg);
                    id_reg <= tr_data.id;
                    rssi_o_reg <= bcn_pkg::rssi_int(tr_data.rssi);
                    bat_reg <= tr_data.bat;
                    typ_reg <= tr_data.typ;
                    seen_reg <= tr_data.seen;
                    occ_reg <= 5'(count_reg);
                    last_reg <= (idx_reg == count_reg - CW'(1));
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= (idx_reg == count_reg - CW'(1)) ? S_IDLE : S_RP_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = ov_reg;
    assign status = status_reg;
    assign slot = slot_reg;
    assign entry_id = id_reg;
    assign rssi_out = rssi_o_reg;
    assign battery_out = bat_reg;
    assign type_out = typ_reg;
    assign last_seen_out = seen_reg;
    assign occupancy = occ_reg;
    assign last = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("entry count above table size");

    a_sweep_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SW_MV |=> count_reg == $past(count_reg) - CW'(1))
        else $error("sweep removal did not shrink the table");

    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> occ_reg == 5'(count_reg))
        else $error("reported occupancy differs from table count");
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the beacon table with smoothed strength and aging.
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        slot;
        logic [31:0]       id;
        logic signed [7:0] rssi;
        logic [7:0]        bat;
        logic [7:0]        typ;
        logic [31:0]       seen;
        logic [4:0]        occ;
        logic              last;
    } sighting_res_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [31:0]       now;
        logic              has;
        logic [31:0]       bid;
        logic [31:0]       mac;
        logic [7:0]        bat;
        logic [7:0]        typ;
        logic signed [7:0] rssi;
        bit                fixed;
        logic [2:0]        st;
        logic [4:0]        occ;
    } request_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        cmd;
    logic [31:0]       now_ms;
    logic              has_data;
    logic [31:0]       beacon_id;
    logic [31:0]       mac_id;
    logic [7:0]        battery_in;
    logic [7:0]        type_in;
    logic signed [7:0] rssi;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic              result_valid;
    logic [2:0]        status;
    logic [3:0]        slot;
    logic [31:0]       entry_id;
    logic signed [7:0] rssi_out;
    logic [7:0]        battery_out;
    logic [7:0]        type_out;
    logic [31:0]       last_seen_out;
    logic [4:0]        occupancy;
    logic              last;

    beacon_table_with_ema_and_aging_top uut (.*);

    // Shadow copy of the table and its registers.
    logic [31:0] tbl_id[TABLE_DEPTH];
    int          tbl_q[TABLE_DEPTH];
    logic [7:0]  tbl_bat[TABLE_DEPTH];
    logic [7:0]  tbl_typ[TABLE_DEPTH];
    logic [31:0] tbl_seen[TABLE_DEPTH];
    int          tbl_n;
    logic        m_show;
    logic [31:0] m_timeout;
    logic [8:0]  m_alpha;

    sighting_res_t pending_results[$];
    int errors;
    int results_seen;
    int requests_sent;
    int swept_seen;
    int full_seen;
    logic [31:0] clock_ms;
    logic [31:0] id_pool[24];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic sighting_res_t entry_res(logic [2:0] st, int s, bit with_entry,
                                                 logic [31:0] id);
        sighting_res_t r;
        r = '0;
        r.status = st;
        r.slot = s[3:0];
        r.id = id;
        if (with_entry)
        begin
            r.rssi = 8'(tbl_q[s] / 256);
            r.bat = tbl_bat[s];
            r.typ = tbl_typ[s];
            r.seen = tbl_seen[s];
        end
        return r;
    endfunction

    function automatic int smooth_rssi(int old, int sample);
        int a;
        int n;
        int r;
        a = (m_alpha > bcn_pkg::ALPHA_ONE) ? 256 : int'(m_alpha);
        n = a * (sample * 256) + (256 - a) * old;
        r = n >>> 8;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    task automatic track_request(input request_t r);
        sighting_res_t batch[$];
        logic [31:0] id;
        logic [7:0]  b;
        logic [7:0]  t;
        logic [31:0] age;
        logic [2:0]  p_st;
        logic [4:0]  p_occ;
        int i;
        bit hit;
        hit = 0;
        case (r.cmd)
            bcn_pkg::CMD_SIGHT:
            begin
                if (!r.has && !m_show)
                begin
                    batch.push_back(entry_res(bcn_pkg::ST_IGNORED, 0, 0, 0));
                end
                else
                begin
                    id = r.has ? r.bid : r.mac;
                    b = r.has ? r.bat : 8'd0;
                    t = r.has ? r.typ : 8'd0;
                    for (i = 0; i < tbl_n && !hit; i++)
                    begin
                        if (tbl_id[i] == id)
                        begin
                            hit = 1;
                            tbl_q[i] = smooth_rssi(tbl_q[i], int'(r.rssi));
                            tbl_bat[i] = b;
                            tbl_typ[i] = t;
                            tbl_seen[i] = r.now;
                            batch.push_back(entry_res(bcn_pkg::ST_UPDATED, i, 1, id));
                        end
                    end
                    if (!hit && tbl_n < TABLE_DEPTH)
                    begin
                        tbl_id[tbl_n] = id;
                        tbl_q[tbl_n] = int'(r.rssi) * 256;
                        tbl_bat[tbl_n] = b;
                        tbl_typ[tbl_n] = t;
                        tbl_seen[tbl_n] = r.now;
                        batch.push_back(entry_res(bcn_pkg::ST_INSERTED, tbl_n, 1, id));
                        tbl_n++;
                    end
                    else if (!hit)
                    begin
                        batch.push_back(entry_res(bcn_pkg::ST_FULL, 0, 0, id));
                    end
                end
            end
            bcn_pkg::CMD_SWEEP:
            begin
                i = 0;
                while (i < tbl_n)
                begin
                    age = r.now - tbl_seen[i];
                    if (age > m_timeout)
                    begin
                        batch.push_back(entry_res(bcn_pkg::ST_SWEPT, i, 1, tbl_id[i]));
                        tbl_n--;
                        tbl_id[i] = tbl_id[tbl_n];
                        tbl_q[i] = tbl_q[tbl_n];
                        tbl_bat[i] = tbl_bat[tbl_n];
                        tbl_typ[i] = tbl_typ[tbl_n];
                        tbl_seen[i] = tbl_seen[tbl_n];
                    end
                    else
                    begin
                        i++;
                    end
                end
            end
            bcn_pkg::CMD_REPORT:
            begin
                if (tbl_n == 0)
                    batch.push_back(entry_res(bcn_pkg::ST_EMPTY, 0, 0, 0));
                for (i = 0; i < tbl_n; i++)
                    batch.push_back(entry_res(bcn_pkg::ST_REPORT, i, 1, tbl_id[i]));
            end
            default:
            begin
            end
        endcase
        foreach (batch[k])
        begin
            batch[k].occ = tbl_n[4:0];
            batch[k].last = (k == batch.size() - 1);
        end
        if (r.fixed && (batch.size() == 0 || batch[0].status != r.st || batch[0].occ != r.occ))
        begin
            errors++;
            p_st = (batch.size() == 0) ? 3'd0 : batch[0].status;
            p_occ = (batch.size() == 0) ? 5'd0 : batch[0].occ;
            if (errors <= 10)
                $display("Directed request cmd %0d: expected status %0d occupancy %0d, %s %0d %0d",
                         r.cmd, r.st, r.occ, "actual status and occupancy", p_st, p_occ);
        end
        foreach (batch[k])
            pending_results.push_back(batch[k]);
    endtask

    // Drives a request at the current edge and returns at the edge that accepts it.
    task automatic send_request(input request_t r);
        logic b;
        start <= 1'b1;
        cmd <= r.cmd;
        now_ms <= r.now;
        has_data <= r.has;
        beacon_id <= r.bid;
        mac_id <= r.mac;
        battery_in <= r.bat;
        type_in <= r.typ;
        rssi <= r.rssi;
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end
        while (b);
        track_request(r);
        requests_sent++;
    endtask

    task automatic sender_gap();
        int g;
        int p;
        p = $urandom_range(99);
        g = (p < 65) ? 0 : (p < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic r;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            r = cfg_ready;
            @(posedge clk);
        end
        while (!r);
        cfg_valid <= 1'b0;
        case (idx)
            bcn_pkg::CFG_SHOW_ALL: m_show = data[0];
            bcn_pkg::CFG_TIMEOUT:  m_timeout = data;
            bcn_pkg::CFG_ALPHA:    m_alpha = data[8:0];
            default:               ;
        endcase
    endtask

    function automatic request_t random_request();
        request_t r;
        int p;
        p = $urandom_range(99);
        r.cmd = (p < 70) ? bcn_pkg::CMD_SIGHT : (p < 82) ? bcn_pkg::CMD_SWEEP :
                (p < 95) ? bcn_pkg::CMD_REPORT : bcn_pkg::CMD_UNUSED;
        p = $urandom_range(99);
        clock_ms = clock_ms + ((p < 90) ? $urandom_range(0, 4000) : $urandom());
        r.now = clock_ms;
        r.has = ($urandom_range(99) < 80);
        r.bid = id_pool[$urandom_range(23)];
        r.mac = ($urandom_range(1)) ? id_pool[$urandom_range(23)] : $urandom();
        r.bat = 8'($urandom());
        r.typ = 8'($urandom());
        r.rssi = 8'($urandom());
        r.fixed = 0;
        r.st = '0;
        r.occ = '0;
        return r;
    endfunction

    always @(negedge clk)
    begin
        sighting_res_t got;
        sighting_res_t want;
        if (rst_n && result_valid)
        begin
            got = '{status, slot, entry_id, rssi_out, battery_out, type_out,
                    last_seen_out, occupancy, last};
            results_seen++;
            if (got.status == bcn_pkg::ST_SWEPT) swept_seen++;
            if (got.status == bcn_pkg::ST_FULL) full_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Result mismatch:\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    request_t plan[20];

    initial
    begin
        logic [31:0] settings[5][3];
        errors = 0;
        results_seen = 0;
        requests_sent = 0;
        swept_seen = 0;
        full_seen = 0;
        tbl_n = 0;
        m_show = 1'b0;
        m_timeout = 32'd120000;
        m_alpha = 9'd77;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = bcn_pkg::CMD_SIGHT;
        now_ms = '0;
        has_data = 1'b0;
        beacon_id = '0;
        mac_id = '0;
        battery_in = '0;
        type_in = '0;
        rssi = '0;
        cfg_valid = 1'b0;
        cfg_index = bcn_pkg::CFG_SHOW_ALL;
        cfg_data = '0;

        plan = '{
            '{bcn_pkg::CMD_REPORT, 32'd0, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              1, bcn_pkg::ST_EMPTY, 5'd0},
            '{bcn_pkg::CMD_SIGHT, 32'd5, 1'b0, 32'd9, 32'd7, 8'd3, 8'd4, 8'sd5,
              1, bcn_pkg::ST_IGNORED, 5'd0},
            '{bcn_pkg::CMD_SWEEP, 32'd10, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              0, bcn_pkg::ST_SWEPT, 5'd0},
            '{bcn_pkg::CMD_UNUSED, 32'd11, 1'b1, 32'd1, 32'd2, 8'd3, 8'd4, 8'sd5,
              0, bcn_pkg::ST_SWEPT, 5'd0},
            '{bcn_pkg::CMD_SIGHT, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'd255, 8'd255, -8'sd128,
              1, bcn_pkg::ST_INSERTED, 5'd1},
            '{bcn_pkg::CMD_SIGHT, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'sd127,
              1, bcn_pkg::ST_INSERTED, 5'd2},
            '{bcn_pkg::CMD_SIGHT, 32'd100, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'd1, 8'd2, 8'sd127,
              1, bcn_pkg::ST_UPDATED, 5'd2},
            '{bcn_pkg::CMD_SIGHT, 32'd200, 1'b1, 32'd0, 32'd0, 8'd9, 8'd8, -8'sd128,
              1, bcn_pkg::ST_UPDATED, 5'd2},
            '{bcn_pkg::CMD_SIGHT, 32'd300, 1'b1, 32'hA5A5_5A5A, 32'd0, 8'hAA, 8'h55, -8'sd1,
              1, bcn_pkg::ST_INSERTED, 5'd3},
            '{bcn_pkg::CMD_SIGHT, 32'd400, 1'b1, 32'hA5A5_5A5A, 32'd0, 8'h55, 8'hAA, 8'sd0,
              0, bcn_pkg::ST_UPDATED, 5'd3},
            '{bcn_pkg::CMD_REPORT, 32'd500, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              1, bcn_pkg::ST_REPORT, 5'd3},
            '{bcn_pkg::CMD_SWEEP, 32'd120100, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              0, bcn_pkg::ST_SWEPT, 5'd0},
            '{bcn_pkg::CMD_SWEEP, 32'd250000, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              1, bcn_pkg::ST_SWEPT, 5'd0},
            '{bcn_pkg::CMD_REPORT, 32'd250001, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              1, bcn_pkg::ST_EMPTY, 5'd0},
            '{bcn_pkg::CMD_SIGHT, 32'd7, 1'b1, 32'h0000_0001, 32'd0, 8'd7, 8'd7, -8'sd60,
              1, bcn_pkg::ST_INSERTED, 5'd1},
            '{bcn_pkg::CMD_SIGHT, 32'd8, 1'b1, 32'h8000_0000, 32'd0, 8'd7, 8'd7, -8'sd70,
              1, bcn_pkg::ST_INSERTED, 5'd2},
            '{bcn_pkg::CMD_SIGHT, 32'd9, 1'b1, 32'h0000_0001, 32'd0, 8'd6, 8'd5, -8'sd90,
              0, bcn_pkg::ST_UPDATED, 5'd2},
            '{bcn_pkg::CMD_SIGHT, 32'd10, 1'b1, 32'h0000_0001, 32'd0, 8'd6, 8'd5, -8'sd90,
              0, bcn_pkg::ST_UPDATED, 5'd2},
            '{bcn_pkg::CMD_SWEEP, 32'd120009, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              0, bcn_pkg::ST_SWEPT, 5'd0},
            '{bcn_pkg::CMD_REPORT, 32'd120010, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 8'sd0,
              0, bcn_pkg::ST_REPORT, 5'd0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            send_request(plan[k]);
            sender_gap();
        end
        drain();

        // Show-all with full-weight smoothing, then a run that fills the table.
        write_reg(bcn_pkg::CFG_SHOW_ALL, 32'd1);
        write_reg(bcn_pkg::CFG_ALPHA, {23'd0, bcn_pkg::ALPHA_ONE});
        for (int k = 0; k < 18; k++)
        begin
            request_t r;
            r = random_request();
            r.cmd = bcn_pkg::CMD_SIGHT;
            r.has = (k % 3 != 0);
            r.bid = 32'h1000 + k;
            r.mac = 32'h2000 + k;
            send_request(r);
            sender_gap();
        end
        drain();

        settings = '{
            '{32'd1, 32'd20000, 32'd77},
            '{32'd0, 32'd0, 32'd0},
            '{32'd1, 32'hFFFF_FFFF, 32'd511},
            '{32'd1, 32'd5000, 32'd256},
            '{32'd0, 32'd120000, 32'd1}
        };
        clock_ms = $urandom();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(bcn_pkg::CFG_SHOW_ALL, settings[ph][0]);
            write_reg(bcn_pkg::CFG_TIMEOUT, settings[ph][1]);
            write_reg(bcn_pkg::CFG_ALPHA, settings[ph][2]);
            foreach (id_pool[k])
                id_pool[k] = (k < 3) ? ((k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : 32'd1)
                                     : $urandom();
            for (int k = 0; k < 62; k++)
            begin
                send_request(random_request());
                sender_gap();
            end
            drain();
        end

        $display("Sent %0d requests over seven register settings; checked %0d results,",
                 requests_sent, results_seen);
        $display("including %0d expired entries and %0d drops on a full table.",
                 swept_seen, full_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
